/* hw/rtl/smva_pkg.sv */
package smva_pkg;

    // Field widths
    localparam int IDX_W     = 10;
    localparam int VEC_W     = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * VEC_W;
    localparam int FRAC_W    = 24;
    localparam int PART_W    = PROD_W - FRAC_W;
    // Wide enough to hold any store depth, for range compares and addressing
    localparam int IDX_EXT_W = 17;

    // Default store depths
    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int RESULT_DEPTH_DEF = 1024;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_LOAD_VEC = 2'd0,
        ACT_LOAD_ACC = 2'd1,
        ACT_APPLY    = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_ACC
    } t_back_state;

    // One classified command: vector address in src_index, accumulator
    // address in dst_index, payload sign-extended into data.
    typedef struct packed {
        t_action           action;
        logic              in_range;
        logic [IDX_W-1:0]  src_index;
        logic [IDX_W-1:0]  dst_index;
        logic [ACC_W-1:0]  data;
    } t_cmd;

endpackage

/* hw/rtl/smva_front.sv */
module smva_front #(
    parameter int VECTOR_DEPTH = smva_pkg::VECTOR_DEPTH_DEF,
    parameter int RESULT_DEPTH = smva_pkg::RESULT_DEPTH_DEF
) (
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_action,
    input  logic [smva_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [smva_pkg::VEC_W-1:0]  i_vector_value,
    input  logic signed [smva_pkg::ACC_W-1:0]  i_accumulator_init,
    input  logic [smva_pkg::IDX_W-1:0]         i_row_index,
    input  logic [smva_pkg::IDX_W-1:0]         i_column_index,
    input  logic signed [smva_pkg::VEC_W-1:0]  i_derivative,
    input  logic                               i_transpose,
    input  logic                               i_full,
    output logic                               o_push,
    output smva_pkg::t_cmd                     o_cmd
);

    localparam int XW  = smva_pkg::IDX_EXT_W;
    localparam int EXT = XW - smva_pkg::IDX_W;
    localparam int SXW = smva_pkg::ACC_W - smva_pkg::VEC_W;
    localparam logic [XW-1:0] VD_L = XW'(VECTOR_DEPTH);
    localparam logic [XW-1:0] RD_L = XW'(RESULT_DEPTH);

    logic [smva_pkg::IDX_W-1:0] w_src;
    logic [smva_pkg::IDX_W-1:0] w_dst;
    logic [XW-1:0]              w_entry_x;
    logic [XW-1:0]              w_src_x;
    logic [XW-1:0]              w_dst_x;
    logic                       w_keep;

    assign w_src     = i_transpose ? i_row_index    : i_column_index;
    assign w_dst     = i_transpose ? i_column_index : i_row_index;
    assign w_entry_x = {{EXT{1'b0}}, i_entry_index};
    assign w_src_x   = {{EXT{1'b0}}, w_src};
    assign w_dst_x   = {{EXT{1'b0}}, w_dst};

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && w_keep;

    always_comb begin
        o_cmd.action    = smva_pkg::t_action'(i_action);
        o_cmd.in_range  = 1'b1;
        o_cmd.src_index = i_entry_index;
        o_cmd.dst_index = i_entry_index;
        o_cmd.data      = i_accumulator_init;
        w_keep          = 1'b1;
        unique case (smva_pkg::t_action'(i_action))
            smva_pkg::ACT_LOAD_VEC: begin
                w_keep     = w_entry_x < VD_L;
                o_cmd.data = {{SXW{i_vector_value[smva_pkg::VEC_W-1]}}, i_vector_value};
            end
            smva_pkg::ACT_LOAD_ACC: begin
                w_keep = w_entry_x < RD_L;
            end
            smva_pkg::ACT_APPLY: begin
                // drop nonzeros that point outside either store
                w_keep          = (w_src_x < VD_L) && (w_dst_x < RD_L);
                o_cmd.src_index = w_src;
                o_cmd.dst_index = w_dst;
                o_cmd.data      = {{SXW{i_derivative[smva_pkg::VEC_W-1]}}, i_derivative};
            end
            smva_pkg::ACT_READ: begin
                o_cmd.in_range = w_entry_x < RD_L;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/smva_fifo.sv */
module smva_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smva_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output smva_pkg::t_cmd o_data
);

    localparam int D   = smva_pkg::QUEUE_DEPTH;
    localparam int PW  = (D > 1) ? $clog2(D) : 1;
    localparam int CW  = $clog2(D + 1);
    localparam logic [PW-1:0] LAST = PW'(D - 1);
    localparam logic [CW-1:0] FULL = CW'(D);

    smva_pkg::t_cmd r_mem [D];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = r_count == FULL;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/smva_back.sv */
module smva_back #(
    parameter int VECTOR_DEPTH = smva_pkg::VECTOR_DEPTH_DEF,
    parameter int RESULT_DEPTH = smva_pkg::RESULT_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  smva_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [smva_pkg::IDX_W-1:0]         o_read_index,
    output logic signed [smva_pkg::ACC_W-1:0]  o_read_value
);

    localparam int VAW  = $clog2(VECTOR_DEPTH);
    localparam int RAW  = $clog2(RESULT_DEPTH);
    localparam int XW   = smva_pkg::IDX_EXT_W;
    localparam int EXT  = XW - smva_pkg::IDX_W;
    localparam int VW   = smva_pkg::VEC_W;
    localparam int AW   = smva_pkg::ACC_W;
    localparam int PW   = smva_pkg::PROD_W;
    localparam int FW   = smva_pkg::FRAC_W;
    localparam int QW   = smva_pkg::PART_W;
    localparam int SW   = AW + 1;

    logic [VW-1:0] r_vec_mem [VECTOR_DEPTH];
    logic [AW-1:0] r_acc_mem [RESULT_DEPTH];

    smva_pkg::t_back_state r_state;
    smva_pkg::t_back_state n_state;

    smva_pkg::t_cmd           r_cmd;
    logic signed [VW-1:0]     r_vec_rd;
    logic signed [AW-1:0]     r_acc_rd;
    logic signed [PW-1:0]     r_prod;
    logic                     r_out_valid;
    logic [smva_pkg::IDX_W-1:0] r_out_index;
    logic signed [AW-1:0]     r_out_value;

    logic [XW-1:0]        w_src_x;
    logic [XW-1:0]        w_dst_x;
    logic [XW-1:0]        w_wb_x;
    logic [VAW-1:0]       w_vaddr;
    logic [RAW-1:0]       w_raddr;
    logic [RAW-1:0]       w_wb_addr;
    logic [RAW-1:0]       w_acc_waddr;
    logic [AW-1:0]        w_acc_wdata;
    logic                 w_vec_we;
    logic                 w_vec_re;
    logic                 w_acc_we;
    logic                 w_acc_re;
    logic                 w_cmd_load;
    logic                 w_prod_load;
    logic                 w_out_load;
    logic signed [PW-1:0] w_prod;
    logic signed [QW-1:0] w_part;
    logic signed [SW-1:0] w_sum;
    logic signed [AW-1:0] w_sat;

    assign w_src_x   = {{EXT{1'b0}}, i_cmd.src_index};
    assign w_dst_x   = {{EXT{1'b0}}, i_cmd.dst_index};
    assign w_wb_x    = {{EXT{1'b0}}, r_cmd.dst_index};
    assign w_vaddr   = w_src_x[VAW-1:0];
    assign w_raddr   = w_dst_x[RAW-1:0];
    assign w_wb_addr = w_wb_x[RAW-1:0];

    // Q8.24 x Q8.24, then floor to 24 fraction bits and saturate the sum
    assign w_prod = $signed(r_cmd.data[VW-1:0]) * r_vec_rd;
    assign w_part = r_prod[PW-1:FW];
    assign w_sum  = {r_acc_rd[AW-1], r_acc_rd} + {{(SW-QW){w_part[QW-1]}}, w_part};
    assign w_sat  = (w_sum[SW-1] != w_sum[SW-2])
                  ? (w_sum[SW-1] ? smva_pkg::ACC_MIN : smva_pkg::ACC_MAX)
                  : w_sum[AW-1:0];

    always_comb begin
        n_state     = r_state;
        o_cmd_pop   = 1'b0;
        w_vec_we    = 1'b0;
        w_vec_re    = 1'b0;
        w_acc_we    = 1'b0;
        w_acc_re    = 1'b0;
        w_cmd_load  = 1'b0;
        w_prod_load = 1'b0;
        w_out_load  = 1'b0;
        w_acc_waddr = w_raddr;
        w_acc_wdata = i_cmd.data;
        unique case (r_state)
            smva_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.action)
                        smva_pkg::ACT_LOAD_VEC: begin
                            w_vec_we = 1'b1;
                        end
                        smva_pkg::ACT_LOAD_ACC: begin
                            w_acc_we = 1'b1;
                        end
                        smva_pkg::ACT_APPLY: begin
                            w_vec_re   = 1'b1;
                            w_acc_re   = 1'b1;
                            w_cmd_load = 1'b1;
                            n_state    = smva_pkg::BK_FETCH;
                        end
                        smva_pkg::ACT_READ: begin
                            w_acc_re   = 1'b1;
                            w_cmd_load = 1'b1;
                            n_state    = smva_pkg::BK_FETCH;
                        end
                        default: begin
                            n_state = smva_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            smva_pkg::BK_FETCH: begin
                if (r_cmd.action == smva_pkg::ACT_APPLY) begin
                    w_prod_load = 1'b1;
                    n_state     = smva_pkg::BK_ACC;
                end else if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = smva_pkg::BK_IDLE;
                end
            end
            smva_pkg::BK_ACC: begin
                w_acc_we    = 1'b1;
                w_acc_waddr = w_wb_addr;
                w_acc_wdata = w_sat;
                n_state     = smva_pkg::BK_IDLE;
            end
            default: begin
                n_state = smva_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_vec_we) begin
            r_vec_mem[w_vaddr] <= i_cmd.data[VW-1:0];
        end
        if (w_vec_re) begin
            r_vec_rd <= r_vec_mem[w_vaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_waddr] <= w_acc_wdata;
        end
        if (w_acc_re) begin
            r_acc_rd <= r_acc_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smva_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd_load) begin
            r_cmd <= i_cmd;
        end
        if (w_prod_load) begin
            r_prod <= w_prod;
        end
        if (w_out_load) begin
            r_out_index <= r_cmd.dst_index;
            r_out_value <= r_cmd.in_range ? r_acc_rd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_index = r_out_index;
    assign o_read_value = r_out_value;

endmodule

/* hw/rtl/coo_sparse_matrix_vector_accumulate.sv */
// A read transaction passes the command queue, the fetch registers and the output register;
// loads write their store from the queue head; nonzero updates go through BK_FETCH and BK_ACC.
// Throughput: 1 load per cycle while the back end is idle; the back end takes no new command
// until a nonzero's read-multiply-writeback sequence on the accumulator memory or a read has finished.
// Reset: synchronous, active low; clears the queue, sequencer, output valid and
// transpose_mode. Vector and accumulator memories hold garbage until written.
module coo_sparse_matrix_vector_accumulate #(
    parameter int VECTOR_DEPTH = smva_pkg::VECTOR_DEPTH_DEF,
    parameter int RESULT_DEPTH = smva_pkg::RESULT_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: transpose_mode
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_action,
    input  logic [smva_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [smva_pkg::VEC_W-1:0]  i_vector_value,
    input  logic signed [smva_pkg::ACC_W-1:0]  i_accumulator_init,
    input  logic [smva_pkg::IDX_W-1:0]         i_row_index,
    input  logic [smva_pkg::IDX_W-1:0]         i_column_index,
    input  logic signed [smva_pkg::VEC_W-1:0]  i_derivative,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [smva_pkg::IDX_W-1:0]         o_read_index,
    output logic signed [smva_pkg::ACC_W-1:0]  o_read_value
);

    logic           r_transpose_mode;
    logic           w_full;
    logic           w_push;
    logic           w_pop;
    logic           w_cmd_valid;
    smva_pkg::t_cmd w_push_cmd;
    smva_pkg::t_cmd w_head_cmd;

    // The user must change mode only while idle; the block does not enforce it. Accept-time sampling relies on it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_transpose_mode <= i_cfg_wdata;
        end
    end

    // Front end: accept the transaction, resolve source/destination by mode,
    // range check, and drop loads and nonzeros that would touch nothing.
    smva_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_front (
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_action           (i_action),
        .i_entry_index      (i_entry_index),
        .i_vector_value     (i_vector_value),
        .i_accumulator_init (i_accumulator_init),
        .i_row_index        (i_row_index),
        .i_column_index     (i_column_index),
        .i_derivative       (i_derivative),
        .i_transpose        (r_transpose_mode),
        .i_full             (w_full),
        .o_push             (w_push),
        .o_cmd              (w_push_cmd)
    );

    // Short command queue decouples acceptance from the memory sequencer.
    smva_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_head_cmd)
    );

    // Back end: one command at a time against the two memories, so a
    // repeated destination always sees the previous writeback.
    smva_back #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_head_cmd),
        .o_cmd_pop    (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_index (o_read_index),
        .o_read_value (o_read_value)
    );

endmodule

/* hw/rtl/smva_checker.sv */
module smva_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic                               i_cfg_wdata,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [1:0]                         i_action,
    input logic [smva_pkg::IDX_W-1:0]         i_entry_index,
    input logic signed [smva_pkg::VEC_W-1:0]  i_vector_value,
    input logic signed [smva_pkg::ACC_W-1:0]  i_accumulator_init,
    input logic [smva_pkg::IDX_W-1:0]         i_row_index,
    input logic [smva_pkg::IDX_W-1:0]         i_column_index,
    input logic signed [smva_pkg::VEC_W-1:0]  i_derivative,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [smva_pkg::IDX_W-1:0]         o_read_index,
    input logic signed [smva_pkg::ACC_W-1:0]  o_read_value
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties the command queue, so input is not stalled.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // The queue can only fill on an accepted transaction.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted transaction");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_read_index) && $stable(o_read_value))
        else $error("stalled result changed");

endmodule

bind coo_sparse_matrix_vector_accumulate smva_checker u_smva_checker (.*);
